>>> sv/assert_macros.svh
// assertion helpers, sampled on i_clk and off while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge
`define FPS_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// condition that implies another one in the next cycle
`define FPS_ASSERT_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

>>> sv/fps_pkg.sv
package fps_pkg;

    localparam int TIME_BITS    = 48;
    localparam int LEN_BITS     = 16;
    localparam int CNT_BITS     = 32;
    localparam int BYTE_BITS    = 48;
    localparam int DIV_STEPS    = BYTE_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [LEN_BITS-1:0]  t_len;
    typedef logic [CNT_BITS-1:0]  t_cnt;
    typedef logic [BYTE_BITS-1:0] t_bytes;

    typedef struct packed {
        logic  start_flow;
        t_time timestamp_us;
        t_len  packet_length;
    } t_pkt;

    typedef struct packed {
        t_cnt   packet_count;
        t_bytes byte_count;
        t_time  min_gap_us;
        t_time  mean_gap_us;
        t_len   mean_length;
        t_time  duration_us;
    } t_stat;

    // record totals right after one packet was added
    typedef struct packed {
        t_cnt   count;
        t_bytes bytes;
        t_time  gap_total;
        t_time  min_gap;
        t_time  first_time;
        t_time  last_time;
    } t_snap;

    typedef struct packed {
        logic   start;
        t_bytes dividend;
        t_cnt   divisor;
    } t_div_req;

    typedef struct packed {
        logic   done;
        t_bytes quotient;
    } t_div_rsp;

endpackage

>>> sv/fps_if.sv
interface fps_pkt_if
    import fps_pkg::*;
();
    logic valid;
    logic ready;
    t_pkt data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fps_stat_if
    import fps_pkg::*;
();
    logic  valid;
    logic  ready;
    t_stat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> sv/fps_front.sv
module fps_front
    import fps_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    fps_pkt_if.sink       i_pkt,
    input  logic          i_full,
    output logic          o_push,
    output t_snap         o_snap
);

    t_cnt   r_count, n_count;
    t_bytes r_bytes, n_bytes;
    t_time  r_first, n_first;
    t_time  r_last, n_last;
    t_time  r_gap_total, n_gap_total;
    t_time  r_min_gap, n_min_gap;

    t_cnt   eff_count;
    t_bytes eff_bytes;
    t_time  eff_last;
    t_time  eff_gap_total;
    t_time  eff_min_gap;
    t_time  gap;
    logic [TIME_BITS:0] gap_sum;
    logic [BYTE_BITS:0] byte_sum;
    logic   accept;

    assign i_pkt.ready = !i_full;
    assign accept      = i_pkt.valid && !i_full;

    // a new flow starts from the cleared record
    always_comb begin
        eff_count     = i_pkt.data.start_flow ? '0 : r_count;
        eff_bytes     = i_pkt.data.start_flow ? '0 : r_bytes;
        eff_last      = i_pkt.data.start_flow ? '0 : r_last;
        eff_gap_total = i_pkt.data.start_flow ? '0 : r_gap_total;
        eff_min_gap   = i_pkt.data.start_flow ? '1 : r_min_gap;
        gap = (i_pkt.data.timestamp_us >= eff_last) ?
              (i_pkt.data.timestamp_us - eff_last) : '0;
        gap_sum  = {1'b0, eff_gap_total} + {1'b0, gap};
        byte_sum = {1'b0, eff_bytes} + {{(BYTE_BITS + 1 - LEN_BITS){1'b0}},
                                        i_pkt.data.packet_length};
    end

    always_comb begin
        n_count     = r_count;
        n_bytes     = r_bytes;
        n_first     = r_first;
        n_last      = r_last;
        n_gap_total = r_gap_total;
        n_min_gap   = r_min_gap;
        if (accept) begin
            n_first     = r_first;
            n_gap_total = eff_gap_total;
            n_min_gap   = eff_min_gap;
            if (eff_count == '0) begin
                n_first = i_pkt.data.timestamp_us;
            end else begin
                n_gap_total = gap_sum[TIME_BITS] ? '1 : gap_sum[TIME_BITS-1:0];
                n_min_gap   = (gap < eff_min_gap) ? gap : eff_min_gap;
            end
            n_last  = i_pkt.data.timestamp_us;
            n_count = (eff_count == '1) ? eff_count : eff_count + t_cnt'(1);
            n_bytes = byte_sum[BYTE_BITS] ? '1 : byte_sum[BYTE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_bytes     <= '0;
            r_first     <= '0;
            r_last      <= '0;
            r_gap_total <= '0;
            r_min_gap   <= '1;
        end else begin
            r_count     <= n_count;
            r_bytes     <= n_bytes;
            r_first     <= n_first;
            r_last      <= n_last;
            r_gap_total <= n_gap_total;
            r_min_gap   <= n_min_gap;
        end
    end

    assign o_push            = accept;
    assign o_snap.count      = n_count;
    assign o_snap.bytes      = n_bytes;
    assign o_snap.gap_total  = n_gap_total;
    assign o_snap.min_gap    = n_min_gap;
    assign o_snap.first_time = n_first;
    assign o_snap.last_time  = n_last;

endmodule

>>> sv/fps_queue.sv
`include "assert_macros.svh"

module fps_queue
    import fps_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_snap i_data,
    output logic  o_full,
    output logic  o_valid,
    output t_snap o_data,
    input  logic  i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_snap          r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `FPS_ASSERT(a_no_push_when_full, !(i_push && o_full), "push into full queue")
    `FPS_ASSERT(a_cnt_in_range, r_cnt <= CW'(DEPTH), "queue count beyond depth")

endmodule

>>> sv/fps_div.sv
`include "assert_macros.svh"

module fps_div
    import fps_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    t_bytes                  r_quo;
    t_cnt                    r_rem;
    t_cnt                    r_div;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic                    r_busy;
    logic                    r_done;

    logic [CNT_BITS:0] rem_sh;
    logic [CNT_BITS:0] diff;
    logic              take;

    // restoring division, one quotient bit per cycle
    assign rem_sh = {r_rem, r_quo[BYTE_BITS-1]};
    assign diff   = rem_sh - {1'b0, r_div};
    assign take   = !diff[CNT_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_BITS'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_BITS'(1);
                if (r_cnt == DIV_CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= take ? diff[CNT_BITS-1:0] : rem_sh[CNT_BITS-1:0];
            r_quo <= {r_quo[BYTE_BITS-2:0], take};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    `FPS_ASSERT(a_start_when_free, !(i_req.start && r_busy), "divider started while busy")

endmodule

>>> sv/fps_back.sv
`include "assert_macros.svh"

module fps_back
    import fps_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_q_valid,
    input  t_snap    i_q_data,
    output logic     o_q_pop,
    output t_div_req o_div,
    input  t_div_rsp i_div,
    fps_stat_if.source o_stat
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_GAP  = 4'b0010,
        S_LEN  = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    t_state r_state, n_state;
    t_snap  r_snap;
    t_time  r_mean_gap;
    t_len   r_mean_len;
    logic   r_ov;
    t_stat  r_out;
    logic   load_out;
    logic   two_plus;

    assign two_plus = (r_snap.count >= t_cnt'(2));
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign load_out = (r_state == S_HOLD) && (!r_ov || o_stat.ready);

    always_comb begin
        o_div.start    = 1'b0;
        o_div.dividend = i_q_data.gap_total;
        o_div.divisor  = i_q_data.count - t_cnt'(1);
        n_state        = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_div.start = 1'b1;
                    n_state     = S_GAP;
                end
            end
            S_GAP: begin
                o_div.dividend = r_snap.bytes;
                o_div.divisor  = r_snap.count;
                if (i_div.done) begin
                    o_div.start = 1'b1;
                    n_state     = S_LEN;
                end
            end
            S_LEN: begin
                if (i_div.done) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_stat.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_snap <= i_q_data;
        end
        if (r_state == S_GAP && i_div.done) begin
            r_mean_gap <= two_plus ? i_div.quotient[TIME_BITS-1:0] : '0;
        end
        if (r_state == S_LEN && i_div.done) begin
            r_mean_len <= (r_snap.count != '0) ? i_div.quotient[LEN_BITS-1:0] : '0;
        end
        if (load_out) begin
            r_out.packet_count <= r_snap.count;
            r_out.byte_count   <= r_snap.bytes;
            r_out.min_gap_us   <= two_plus ? r_snap.min_gap : '0;
            r_out.mean_gap_us  <= r_mean_gap;
            r_out.mean_length  <= r_mean_len;
            r_out.duration_us  <= (r_snap.last_time >= r_snap.first_time) ?
                                  (r_snap.last_time - r_snap.first_time) : '0;
        end
    end

    assign o_stat.valid = r_ov;
    assign o_stat.data  = r_out;

    `FPS_ASSERT(a_done_while_dividing, !i_div.done || r_state == S_GAP || r_state == S_LEN,
        "divider result outside a division state")
    `FPS_ASSERT_NEXT(a_load_sets_valid, load_out, r_ov, "loaded result not presented")

endmodule

>>> sv/flow_packet_statistics_unit.sv
// Flow packet statistics. Each packet transaction on i_pkt is folded into the running flow
// record in the cycle it is accepted (start_flow clears the record first), and a copy of the
// record totals goes into a short queue; i_pkt takes one packet per cycle while the queue has
// room. The back end turns each queued record into one statistics transaction on o_stat,
// in order, using one shared serial divider for the mean gap and then the mean length: two
// 48-step divisions per result, done one after the other, so the divider sets the sustained
// rate. A finished result waits in an output register while the next one is being computed.
// Mean gap divides by count-1 and reads 0 with fewer than two packets, as does the minimum
// gap; counts and totals saturate.
module flow_packet_statistics_unit
    import fps_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fps_pkt_if.sink    i_pkt,
    fps_stat_if.source o_stat
);

    logic     push, full, q_valid, q_pop;
    t_snap    push_data, q_data;
    t_div_req div_req;
    t_div_rsp div_rsp;

    fps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (i_pkt),
        .i_full  (full),
        .o_push  (push),
        .o_snap  (push_data)
    );

    fps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    fps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    fps_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_div     (div_req),
        .i_div     (div_rsp),
        .o_stat    (o_stat)
    );

endmodule

>>> bench/flow_packet_statistics_unit_tb.sv
`timescale 1ns / 100ps

module flow_packet_statistics_unit_tb;
    import fps_pkg::*;

    localparam int     RANDOM_ITEMS     = 1750;
    localparam int     QUIET_TAIL       = 250;
    localparam int     LONG_HOLD_CYCLES = 600;
    localparam int     DRAIN_CYCLES     = 300;
    localparam int     MAX_REPORTS      = 10;
    localparam t_time  TIME_MAX         = '1;
    localparam t_bytes BYTES_MAX        = '1;

    class flow_record_tracker;
        t_cnt   pkt_cnt;
        t_bytes byte_sum;
        t_time  first_ts;
        t_time  last_ts;
        t_time  gap_sum;
        t_time  min_gap;
        t_stat  pending_stats[$];
        int     errors;

        function new();
            errors = 0;
            open_record();
        endfunction

        function void open_record();
            pkt_cnt  = '0;
            byte_sum = '0;
            first_ts = '0;
            last_ts  = '0;
            gap_sum  = '0;
            min_gap  = TIME_MAX;
        endfunction

        // fold one accepted packet into the record and queue the statistics it yields
        function void fold_packet(t_pkt p);
            logic [63:0] gap;
            logic [63:0] sum;
            t_stat       s;
            if (p.start_flow) open_record();
            if (pkt_cnt == 0) begin
                first_ts = p.timestamp_us;
            end else begin
                gap = (p.timestamp_us >= last_ts) ? 64'(p.timestamp_us - last_ts) : 64'd0;
                sum = 64'(gap_sum) + gap;
                gap_sum = (sum > 64'(TIME_MAX)) ? TIME_MAX : t_time'(sum);
                if (gap < 64'(min_gap)) min_gap = t_time'(gap);
            end
            last_ts = p.timestamp_us;
            if (pkt_cnt != '1) pkt_cnt = pkt_cnt + 1;
            sum = 64'(byte_sum) + 64'(p.packet_length);
            byte_sum = (sum > 64'(BYTES_MAX)) ? BYTES_MAX : t_bytes'(sum);

            s.packet_count = pkt_cnt;
            s.byte_count   = byte_sum;
            s.min_gap_us   = (pkt_cnt >= 2) ? min_gap : '0;
            s.mean_gap_us  = (pkt_cnt >= 2) ? t_time'(64'(gap_sum) / 64'(pkt_cnt - 1)) : '0;
            s.mean_length  = t_len'(64'(byte_sum) / 64'(pkt_cnt));
            s.duration_us  = (last_ts >= first_ts) ? t_time'(last_ts - first_ts) : '0;
            pending_stats = {pending_stats, s};
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= MAX_REPORTS) $display("%0t mismatch: %s", $time, msg);
        endfunction

        function void check_field(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                note_error($sformatf("%s expected %0d actual %0d", field, want, got));
            end
        endfunction

        function void compare_stat(t_stat got);
            t_stat want;
            if (pending_stats.size() == 0) begin
                note_error("statistics transaction with no packet pending");
                return;
            end
            want = pending_stats.pop_front();
            check_field("packet_count", want.packet_count, got.packet_count);
            check_field("byte_count", want.byte_count, got.byte_count);
            check_field("min_gap_us", want.min_gap_us, got.min_gap_us);
            check_field("mean_gap_us", want.mean_gap_us, got.mean_gap_us);
            check_field("mean_length", want.mean_length, got.mean_length);
            check_field("duration_us", want.duration_us, got.duration_us);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   idling_on;
    bit   long_hold_req;
    int   sent_count;

    fps_pkt_if  pkt_if ();
    fps_stat_if stat_if ();

    flow_record_tracker tracker = new();

    flow_packet_statistics_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (pkt_if),
        .o_stat  (stat_if)
    );

    always #2 i_clk = ~i_clk;

    task automatic send_packet(input logic start, input t_time ts, input t_len len);
        t_pkt p;
        p.start_flow    = start;
        p.timestamp_us  = ts;
        p.packet_length = len;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            pkt_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        pkt_if.valid <= 1'b1;
        pkt_if.data  <= p;
        @(posedge i_clk);
        while (!pkt_if.ready) @(posedge i_clk);
        tracker.fold_packet(p);
        sent_count++;
    endtask

    task automatic send_random_records();
        t_time ts;
        t_len  len;
        int    rec_len;
        int    pick;
        logic  start;
        long_hold_req = 1'b1;
        while (sent_count < RANDOM_ITEMS) begin
            idling_on = ((sent_count / 150) % 3 != 2) && (sent_count < RANDOM_ITEMS - QUIET_TAIL);
            rec_len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
            pick = $urandom_range(0, 9);
            ts = (pick < 2) ? TIME_MAX - t_time'($urandom_range(0, 5000))
                            : t_time'({$urandom, $urandom});
            start = ($urandom_range(0, 9) != 0);
            for (int k = 0; k < rec_len; k++) begin
                if (k > 0) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 65) begin
                        ts = ts + t_time'($urandom_range(0, 200));
                    end else if (pick < 80) begin
                        ts = ts + t_time'($urandom);
                    end else if (pick < 92) begin
                        ts = ts - t_time'($urandom_range(1, 1000));
                    end else begin
                        ts = t_time'({$urandom, $urandom});
                    end
                    start = ($urandom_range(0, 49) == 0);
                end
                pick = $urandom_range(0, 9);
                len = (pick == 0) ? '0 : (pick == 1) ? '1 : t_len'($urandom);
                send_packet(start, ts, len);
            end
        end
    endtask

    // receiving side: check, then pick the next ready level
    initial begin
        int stall_left;
        stall_left    = 0;
        stat_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (stat_if.valid && stat_if.ready) tracker.compare_stat(stat_if.data);
            if (stall_left > 0) begin
                stall_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD_CYCLES;
            end else if (idling_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 16);
            end
            stat_if.ready <= (stall_left == 0);
        end
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        pkt_if.valid  = 1'b0;
        pkt_if.data   = '0;
        idling_on     = 1'b1;
        long_hold_req = 1'b0;
        sent_count    = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty record without start, then a decreasing and an early timestamp
        send_packet(1'b0, 48'd1000, 16'd0);
        send_packet(1'b0, 48'd1010, 16'hFFFF);
        send_packet(1'b0, 48'd1005, 16'd1);
        send_packet(1'b0, 48'd900, 16'd100);
        // full-range gaps drive the gap total into saturation
        send_packet(1'b1, 48'd0, 16'hFFFF);
        send_packet(1'b0, TIME_MAX, 16'hFFFF);
        send_packet(1'b0, 48'd0, 16'hFFFF);
        send_packet(1'b0, TIME_MAX, 16'hFFFF);
        send_packet(1'b1, TIME_MAX, 16'd0);
        send_packet(1'b0, TIME_MAX, 16'd0);
        // alternating bit patterns
        send_packet(1'b1, 48'h5555_5555_5555, 16'hAAAA);
        send_packet(1'b0, 48'hAAAA_AAAA_AAAA, 16'h5555);
        send_packet(1'b0, 48'hAAAA_AAAA_AAAB, 16'h8000);
        // equal timestamps
        send_packet(1'b1, 48'd7, 16'd1);
        send_packet(1'b0, 48'd7, 16'd1);
        send_packet(1'b0, 48'd7, 16'd2);

        send_random_records();
        pkt_if.valid <= 1'b0;

        while (tracker.pending_stats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending_stats.size() == 0) begin
            $display("flow_packet_statistics_unit_tb: done, clean");
        end else begin
            $display("flow_packet_statistics_unit_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("flow_packet_statistics_unit_tb: done, errors");
        $finish;
    end

endmodule
